// File: src/vhfc_pkg.sv
`default_nettype none
package vhfc_pkg;

	localparam int CHUNK_EDGE  = 16;
	localparam int COORD_W     = 4;
	localparam int FACE_COUNT  = 6;
	localparam int VOXEL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int INDEX_W     = $clog2(VOXEL_COUNT);
	localparam int ENTRY_W     = FACE_COUNT + 1;
	localparam int OCC_BIT     = FACE_COUNT;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [FACE_COUNT-1:0] ALL_FACES = 6'h3F;

	typedef struct packed {
		logic                  command;
		logic [COORD_W-1:0]    pos_x;
		logic [COORD_W-1:0]    pos_y;
		logic [COORD_W-1:0]    pos_z;
		logic                  occupied;
		logic [FACE_COUNT-1:0] solid_mask;
	} in_word_t;

	typedef struct packed {
		logic                  found;
		logic [FACE_COUNT-1:0] visible_faces;
	} out_word_t;

	typedef struct packed {
		logic               we;
		logic [INDEX_W-1:0] addr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [INDEX_W-1:0] vox_index(
		input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z
	);
		int sum;
		sum = int'(x) + int'(y) * CHUNK_EDGE + int'(z) * CHUNK_EDGE * CHUNK_EDGE;
		return INDEX_W'(sum);
	endfunction

	function automatic logic coord_inside(input logic [COORD_W:0] c);
		return int'(c) < CHUNK_EDGE;
	endfunction

endpackage
`default_nettype wire

// File: src/vhfc_store.sv
`default_nettype none
module vhfc_store (
	input  wire logic                        clk,
	input  wire vhfc_pkg::mem_req_t          req,
	output logic [vhfc_pkg::ENTRY_W-1:0]     rdata
);
	import vhfc_pkg::*;

	logic [ENTRY_W-1:0] mem [VOXEL_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else begin
			rdata <= mem[req.addr];
		end
	end

endmodule
`default_nettype wire

// File: src/vhfc_ctrl.sv
`default_nettype none
module vhfc_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire vhfc_pkg::in_word_t       cmd,
	output logic                          busy,
	output logic                          result_valid,
	output vhfc_pkg::out_word_t           result,
	output vhfc_pkg::mem_req_t            req,
	input  wire logic [vhfc_pkg::ENTRY_W-1:0] rdata
);
	import vhfc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_QUERY,
		ST_LAST
	} state_t;

	localparam logic [2:0] PH_SELF = 3'd0;
	localparam logic [2:0] PH_PX   = 3'd1;
	localparam logic [2:0] PH_NX   = 3'd2;
	localparam logic [2:0] PH_PY   = 3'd3;
	localparam logic [2:0] PH_NY   = 3'd4;
	localparam logic [2:0] PH_PZ   = 3'd5;
	localparam logic [2:0] PH_NZ   = 3'd6;

	state_t                state_q;
	in_word_t              item_q;
	logic                  self_ok_q;
	logic [2:0]            phase_q;
	logic [INDEX_W-1:0]    clr_q;
	logic                  self_occ_q;
	logic [FACE_COUNT-1:0] vis_q;
	logic                  rd_s1;
	logic [2:0]            phase_s1;
	logic                  nbok_s1;

	logic [COORD_W:0]      cx, cy, cz;
	logic [COORD_W:0]      nx, ny, nz;
	logic                  nb_ok;
	logic                  self_ok_in;
	logic [2:0]            face_d;
	logic [2:0]            face_opp;
	logic                  self_occ_n;
	logic [FACE_COUNT-1:0] vis_n;

	assign busy = (state_q != ST_IDLE);

	assign self_ok_in = coord_inside({1'b0, cmd.pos_x}) && coord_inside({1'b0, cmd.pos_y})
		&& coord_inside({1'b0, cmd.pos_z});

	assign cx = {1'b0, item_q.pos_x};
	assign cy = {1'b0, item_q.pos_y};
	assign cz = {1'b0, item_q.pos_z};

	always_comb begin
		nx = cx;
		ny = cy;
		nz = cz;
		case (phase_q)
			PH_SELF: begin
			end
			PH_PX: nx = cx + 1'b1;
			PH_NX: nx = cx - 1'b1;
			PH_PY: ny = cy + 1'b1;
			PH_NY: ny = cy - 1'b1;
			PH_PZ: nz = cz + 1'b1;
			PH_NZ: nz = cz - 1'b1;
			default: begin
			end
		endcase
		nb_ok = coord_inside(nx) && coord_inside(ny) && coord_inside(nz);
	end

	always_comb begin
		req.we    = 1'b0;
		req.addr  = vox_index(nx[COORD_W-1:0], ny[COORD_W-1:0], nz[COORD_W-1:0]);
		req.wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				req.we   = 1'b1;
				req.addr = clr_q;
			end
			ST_WRITE: begin
				req.we    = self_ok_q;
				req.wdata = {item_q.occupied, item_q.solid_mask};
			end
			default: begin
			end
		endcase
	end

	// Each returned neighbor entry can hide the face it sits across from.
	always_comb begin
		face_d     = phase_s1 - 3'd1;
		face_opp   = face_d ^ 3'd1;
		self_occ_n = self_occ_q;
		vis_n      = vis_q;
		if (rd_s1) begin
			if (phase_s1 == PH_SELF) begin
				self_occ_n = nbok_s1 && rdata[OCC_BIT];
				vis_n      = ALL_FACES;
			end else if (nbok_s1 && rdata[OCC_BIT] && rdata[face_opp]) begin
				vis_n[face_d] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			phase_q      <= PH_SELF;
			rd_s1        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			rd_s1        <= (state_q == ST_QUERY);
			phase_s1     <= phase_q;
			nbok_s1      <= nb_ok;
			self_occ_q   <= self_occ_n;
			vis_q        <= vis_n;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == INDEX_W'(VOXEL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						item_q    <= cmd;
						self_ok_q <= self_ok_in;
						phase_q   <= PH_SELF;
						state_q   <= (cmd.command == CMD_QUERY) ? ST_QUERY : ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_QUERY: begin
					if (phase_q == PH_NZ) begin
						state_q <= ST_LAST;
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				ST_LAST: begin
					result_valid         <= 1'b1;
					result.found         <= self_occ_n;
					result.visible_faces <= self_occ_n ? vis_n : '0;
					state_q              <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_LAST))
		else $error("result strobe without a finished query");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
		else $error("store written outside clear or write");

	a_empty_no_faces: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |-> (result.visible_faces == '0))
		else $error("faces reported for an empty voxel");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QUERY) |-> (phase_q <= PH_NZ))
		else $error("query phase out of range");

endmodule
`default_nettype wire

// File: src/voxel_hidden_face_cull.sv
// Hidden-face culling for one chunk of voxels. A word is taken at a clock edge where start is
// high and busy is low; the receiver cannot stall, so each query result appears on result for
// exactly one cycle with result_valid high. A write passes through the write state and gives
// no result. A query reads its own voxel and six neighbors through the single port of the
// voxel memory, one read per cycle; the last read returns in the final state, and result_valid
// rises at the same clock edge at which busy falls, so a new word is not taken until the
// previous query has finished. After reset the memory is cleared one entry per cycle,
// holding busy high until every entry is cleared.
`default_nettype none
module voxel_hidden_face_cull (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire vhfc_pkg::in_word_t   cmd,
	output logic                      busy,
	output logic                      result_valid,
	output vhfc_pkg::out_word_t       result
);
	import vhfc_pkg::*;

	mem_req_t           req;
	logic [ENTRY_W-1:0] rdata;

	vhfc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.req          (req),
		.rdata        (rdata)
	);

	vhfc_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule
`default_nettype wire
